[rtl/sflc_pkg.sv]
// ----------------------------------------------------------------------------
// sflc_pkg
// Types and codes shared by the start/length frame checker modules.
// ----------------------------------------------------------------------------
`default_nettype none

package sflc_pkg;

  // configuration register indexes
  localparam int CFG_INDEX_W = 2;
  localparam logic [CFG_INDEX_W-1:0] REG_START_BYTE    = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_PAYLOAD_LIMIT = 2'd1;

  localparam logic [7:0] START_BYTE_RESET    = 8'd254;
  localparam logic [7:0] PAYLOAD_LIMIT_RESET = 8'd255;

  // result kinds
  localparam logic KIND_PAYLOAD = 1'b0;
  localparam logic KIND_STATUS  = 1'b1;

  // receive parser phases
  typedef enum logic [2:0] {
    PH_START   = 3'd0,
    PH_LEN     = 3'd1,
    PH_CMD0    = 3'd2,
    PH_CMD1    = 3'd3,
    PH_PAYLOAD = 3'd4,
    PH_CHECK   = 3'd5,
    PH_DONE    = 3'd6,
    PH_BAD     = 3'd7
  } phase_t;

  // frame status codes
  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_CORRUPT = 2'd1,
    ST_NOSPACE = 2'd2
  } status_t;

  // work handed from the front to the back for one accepted byte
  typedef struct packed {
    logic       has_payload;
    logic       has_status;
    logic [7:0] pay_byte;
    status_t    status;
    logic [7:0] cmd0;
    logic [7:0] cmd1;
    logic [7:0] length;
  } entry_t;

  // queue fill flags seen by both sides
  typedef struct packed {
    logic full;
    logic empty;
  } queue_flags_t;

endpackage

`default_nettype wire

[rtl/sflc_if.sv]
// ----------------------------------------------------------------------------
// sflc_if
// Valid/ready channels for the receive bytes and the checker results.
// ----------------------------------------------------------------------------
`default_nettype none

interface sflc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       buffer_last;

  modport source (output valid, output in_byte, output buffer_last, input ready);
  modport sink   (input valid, input in_byte, input buffer_last, output ready);
endinterface

interface sflc_out_if;
  logic       valid;
  logic       ready;
  logic       result_kind;
  logic [7:0] out_byte;
  logic [1:0] frame_status;
  logic [7:0] command_0;
  logic [7:0] command_1;
  logic [7:0] frame_length;
  logic       last_of_run;

  modport source (output valid, output result_kind, output out_byte, output frame_status,
                  output command_0, output command_1, output frame_length,
                  output last_of_run, input ready);
  modport sink   (input valid, input result_kind, input out_byte, input frame_status,
                  input command_0, input command_1, input frame_length,
                  input last_of_run, output ready);
endinterface

`default_nettype wire

[rtl/sflc_front.sv]
// ----------------------------------------------------------------------------
// sflc_front
// Accepts receive bytes, tracks the frame phase and check byte, and queues
// the payload and status results each byte causes.
// ----------------------------------------------------------------------------
`default_nettype none

module sflc_front (
  input  wire logic                             clk,
  input  wire logic                             rst,
  sflc_in_if.sink                               bytes_in,
  input  wire logic                             cfg_we,
  input  wire logic [sflc_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [7:0]                       cfg_data,
  input  wire sflc_pkg::queue_flags_t           flags,
  output logic                                  push,
  output sflc_pkg::entry_t                      push_entry
);

  logic [7:0] start_byte;
  logic [7:0] payload_limit;

  sflc_pkg::phase_t phase, phase_next;
  logic [7:0] bytes_seen, bytes_seen_next;
  logic [7:0] length_held, length_held_next;
  logic [7:0] cmd0_held, cmd0_held_next;
  logic [7:0] cmd1_held, cmd1_held_next;
  logic [7:0] check_acc, check_acc_next;

  // values after this beat, before the buffer end clears them
  sflc_pkg::phase_t ph_a;
  logic [7:0] cnt_a, len_a, c0_a, c1_a, acc_a;
  logic       pay_a;
  sflc_pkg::status_t st_a;
  logic       accept;

  assign bytes_in.ready = !flags.full;
  assign accept = bytes_in.valid && bytes_in.ready;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      start_byte    <= sflc_pkg::START_BYTE_RESET;
      payload_limit <= sflc_pkg::PAYLOAD_LIMIT_RESET;
    end else if (cfg_we) begin
      if (cfg_index == sflc_pkg::REG_START_BYTE) begin
        start_byte <= cfg_data;
      end else if (cfg_index == sflc_pkg::REG_PAYLOAD_LIMIT) begin
        payload_limit <= cfg_data;
      end
    end
  end

  // phase state register
  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= sflc_pkg::PH_START;
      bytes_seen  <= '0;
      length_held <= '0;
      cmd0_held   <= '0;
      cmd1_held   <= '0;
      check_acc   <= '0;
    end else begin
      phase       <= phase_next;
      bytes_seen  <= bytes_seen_next;
      length_held <= length_held_next;
      cmd0_held   <= cmd0_held_next;
      cmd1_held   <= cmd1_held_next;
      check_acc   <= check_acc_next;
    end
  end

  // next phase, running check and queued work
  always_comb begin
    ph_a  = phase;
    cnt_a = bytes_seen;
    len_a = length_held;
    c0_a  = cmd0_held;
    c1_a  = cmd1_held;
    acc_a = check_acc;
    pay_a = 1'b0;

    unique case (phase)
      sflc_pkg::PH_START: begin
        ph_a = (bytes_in.in_byte == start_byte) ? sflc_pkg::PH_LEN : sflc_pkg::PH_BAD;
      end
      sflc_pkg::PH_LEN: begin
        len_a = bytes_in.in_byte;
        acc_a = bytes_in.in_byte;
        ph_a  = sflc_pkg::PH_CMD0;
      end
      sflc_pkg::PH_CMD0: begin
        c0_a  = bytes_in.in_byte;
        acc_a = check_acc ^ bytes_in.in_byte;
        ph_a  = sflc_pkg::PH_CMD1;
      end
      sflc_pkg::PH_CMD1: begin
        c1_a  = bytes_in.in_byte;
        acc_a = check_acc ^ bytes_in.in_byte;
        cnt_a = '0;
        ph_a  = (length_held == 8'd0) ? sflc_pkg::PH_CHECK : sflc_pkg::PH_PAYLOAD;
      end
      sflc_pkg::PH_PAYLOAD: begin
        pay_a = 1'b1;
        acc_a = check_acc ^ bytes_in.in_byte;
        cnt_a = bytes_seen + 8'd1;
        if (cnt_a >= length_held) begin
          ph_a = sflc_pkg::PH_CHECK;
        end
      end
      sflc_pkg::PH_CHECK: begin
        acc_a = check_acc ^ bytes_in.in_byte;
        ph_a  = sflc_pkg::PH_DONE;
      end
      sflc_pkg::PH_DONE, sflc_pkg::PH_BAD: begin
        ph_a = phase;
      end
    endcase

    // status at buffer end; no space wins over a check mismatch
    if (ph_a != sflc_pkg::PH_DONE) begin
      st_a = sflc_pkg::ST_CORRUPT;
    end else if (len_a > payload_limit) begin
      st_a = sflc_pkg::ST_NOSPACE;
    end else if (acc_a != 8'd0) begin
      st_a = sflc_pkg::ST_CORRUPT;
    end else begin
      st_a = sflc_pkg::ST_OK;
    end

    push_entry.has_payload = pay_a;
    push_entry.has_status  = bytes_in.buffer_last;
    push_entry.pay_byte    = bytes_in.in_byte;
    push_entry.status      = st_a;
    push_entry.cmd0        = c0_a;
    push_entry.cmd1        = c1_a;
    push_entry.length      = len_a;
    push = accept && (pay_a || bytes_in.buffer_last);

    phase_next       = phase;
    bytes_seen_next  = bytes_seen;
    length_held_next = length_held;
    cmd0_held_next   = cmd0_held;
    cmd1_held_next   = cmd1_held;
    check_acc_next   = check_acc;
    if (accept) begin
      if (bytes_in.buffer_last) begin
        phase_next       = sflc_pkg::PH_START;
        bytes_seen_next  = '0;
        length_held_next = '0;
        cmd0_held_next   = '0;
        cmd1_held_next   = '0;
        check_acc_next   = '0;
      end else begin
        phase_next       = ph_a;
        bytes_seen_next  = cnt_a;
        length_held_next = len_a;
        cmd0_held_next   = c0_a;
        cmd1_held_next   = c1_a;
        check_acc_next   = acc_a;
      end
    end
  end

endmodule

`default_nettype wire

[rtl/sflc_queue.sv]
// ----------------------------------------------------------------------------
// sflc_queue
// Short register queue of pending work between the front and the back.
// ----------------------------------------------------------------------------
`default_nettype none

module sflc_queue #(
  parameter int DEPTH = 4
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              push,
  input  wire sflc_pkg::entry_t  push_entry,
  input  wire logic              pop,
  output sflc_pkg::entry_t       head,
  output sflc_pkg::queue_flags_t flags
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  sflc_pkg::entry_t slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr, rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push, do_pop;

  assign flags.full  = (count == CNT_W'(DEPTH));
  assign flags.empty = (count == '0);
  assign do_push = push && !flags.full;
  assign do_pop  = pop && !flags.empty;
  assign head    = slots[rd_ptr];

  // storage, no reset needed
  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_entry;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + CNT_W'(1);
      end else if (do_pop && !do_push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

endmodule

`default_nettype wire

[rtl/sflc_back.sv]
// ----------------------------------------------------------------------------
// sflc_back
// Expands queued work into result beats: a payload beat, a status beat, or
// both in turn, through a registered output stage.
// ----------------------------------------------------------------------------
`default_nettype none

module sflc_back (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire sflc_pkg::entry_t       head,
  input  wire sflc_pkg::queue_flags_t flags,
  output logic                        pop,
  sflc_out_if.source                  results
);

  logic       out_valid;
  logic       second, second_next;
  logic       load, emit;
  logic       kind_n, last_n;
  logic [7:0] byte_n, c0_n, c1_n, len_n;
  logic [1:0] status_n;

  logic       kind_r, last_r;
  logic [7:0] byte_r, c0_r, c1_r, len_r;
  logic [1:0] status_r;

  assign load = !out_valid || results.ready;

  // pick the next beat from the head entry
  always_comb begin
    pop         = 1'b0;
    emit        = 1'b0;
    second_next = second;
    kind_n      = sflc_pkg::KIND_PAYLOAD;
    byte_n      = head.pay_byte;
    status_n    = sflc_pkg::ST_OK;
    c0_n        = head.cmd0;
    c1_n        = head.cmd1;
    len_n       = head.length;
    last_n      = 1'b1;
    if (load && !flags.empty) begin
      emit = 1'b1;
      if (head.has_payload && !second) begin
        last_n = !head.has_status;
        if (head.has_status) begin
          second_next = 1'b1;
        end else begin
          pop = 1'b1;
        end
      end else begin
        kind_n      = sflc_pkg::KIND_STATUS;
        byte_n      = 8'd0;
        status_n    = head.status;
        pop         = 1'b1;
        second_next = 1'b0;
        // a status beat carries the header fields only for a good frame
        if (head.status != sflc_pkg::ST_OK) begin
          c0_n  = 8'd0;
          c1_n  = 8'd0;
          len_n = 8'd0;
        end
      end
    end
  end

  // output control
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      second    <= 1'b0;
    end else if (load) begin
      out_valid <= emit;
      second    <= second_next;
    end
  end

  // output payload
  always_ff @(posedge clk) begin
    if (load && emit) begin
      kind_r   <= kind_n;
      byte_r   <= byte_n;
      status_r <= status_n;
      c0_r     <= c0_n;
      c1_r     <= c1_n;
      len_r    <= len_n;
      last_r   <= last_n;
    end
  end

  assign results.valid        = out_valid;
  assign results.result_kind  = kind_r;
  assign results.out_byte     = byte_r;
  assign results.frame_status = status_r;
  assign results.command_0    = c0_r;
  assign results.command_1    = c1_r;
  assign results.frame_length = len_r;
  assign results.last_of_run  = last_r;

endmodule

`default_nettype wire

[rtl/sof_length_frame_checker.sv]
// ----------------------------------------------------------------------------
// sof_length_frame_checker
// Checks start byte, length, command bytes, payload and XOR check byte of
// one frame per receive buffer; passes payload bytes and one status beat.
// ----------------------------------------------------------------------------
//  channel    dir  handshake      content
//  bytes_in   in   valid/ready    in_byte, buffer_last
//  results    out  valid/ready    kind, byte, status, commands, length, last
//  cfg        in   cfg_we only    cfg_index, cfg_data (start byte, limit)
//
//  one byte is taken per cycle; the front parser is a single compare/XOR step
//  results are registered in the queue and the output stage; a buffer end
//  with a payload byte yields two beats, the queue absorbs the extra one
//  bytes_in stalls only while the queue is full; results stall freely
//  synchronous reset returns to expecting a start byte, no clearing pass
// ----------------------------------------------------------------------------
`default_nettype none

module sof_length_frame_checker #(
  parameter int QUEUE_DEPTH = 4
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  sflc_in_if.sink                               bytes_in,
  sflc_out_if.source                            results,
  input  wire logic                             cfg_we,
  input  wire logic [sflc_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [7:0]                       cfg_data
);

  sflc_pkg::entry_t       push_entry;
  sflc_pkg::entry_t       head;
  sflc_pkg::queue_flags_t flags;
  logic                   push;
  logic                   pop;

  // parser and classifier
  sflc_front u_front (
    .clk        (clk),
    .rst        (rst),
    .bytes_in   (bytes_in),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .flags      (flags),
    .push       (push),
    .push_entry (push_entry)
  );

  // decoupling queue
  sflc_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .head       (head),
    .flags      (flags)
  );

  // result emitter
  sflc_back u_back (
    .clk     (clk),
    .rst     (rst),
    .head    (head),
    .flags   (flags),
    .pop     (pop),
    .results (results)
  );

endmodule

`default_nettype wire
